>>> sv/iols_pkg.sv
// ----------------------------------------------------------------------------
// iols_pkg: shared types and codes for the indexed ordered list store
// Request action codes and the command broadcast to every storage cell.
// ----------------------------------------------------------------------------
package iols_pkg;

  localparam int ACTION_W   = 3;
  localparam int POSITION_W = 7;
  localparam int VALUE_W    = 32;
  localparam int LENGTH_W   = 7;

  // request action codes
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FRONT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_BEFORE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;

  // command seen by every cell in the chain
  typedef struct packed {
    logic ins;  // open a slot at the target and write the new value there
    logic del;  // close the slot at the target
  } cell_cmd_t;

endpackage

>>> sv/iols_cell.sv
// ----------------------------------------------------------------------------
// iols_cell: one storage slot of the list chain
// Holds one entry; on insert, above the target it takes its lower neighbor
// and at it the new value; on delete from the target up its upper; else holds.
// ----------------------------------------------------------------------------
module iols_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 7
) (
  input  logic                               clk,
  input  iols_pkg::cell_cmd_t                cmd,
  input  logic [CMP_W-1:0]                   target,
  input  logic [iols_pkg::VALUE_W-1:0]       ins_value,
  input  logic [iols_pkg::VALUE_W-1:0]       lower_q,
  input  logic [iols_pkg::VALUE_W-1:0]       upper_q,
  output logic [iols_pkg::VALUE_W-1:0]       q
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [iols_pkg::VALUE_W-1:0] q_next;

  // select what this slot holds after the request
  always_comb begin
    q_next = q;
    priority if (cmd.ins && (MY_IDX > target)) begin
      q_next = lower_q;
    end else if (cmd.ins && (MY_IDX == target)) begin
      q_next = ins_value;
    end else if (cmd.del && (MY_IDX >= target)) begin
      q_next = upper_q;
    end else begin
      q_next = q;
    end
  end

  // hold the entry; payload needs no reset
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> sv/indexed_ordered_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_store_top: bounded ordered list in a chain of cells
// Reads, inserts (front, back, before a position) and deletes list entries.
//
//   channel  | signals                               | handshake
//   ---------+---------------------------------------+------------------------
//   request  | action, position, item_value          | start && !busy
//   result   | read_value, accepted, list_length     | done, one cycle, no stall
//
// One request per cycle: every cell shifts in the same cycle, so the whole
// insert or delete finishes at the accepting edge. The result appears in the
// cycle after acceptance, set by the registered output stage. busy stays low.
// Reset (rst, synchronous) empties the list; entries themselves are not
// cleared and are only ever read after being written.
// ----------------------------------------------------------------------------
module indexed_ordered_list_store_top #(
  parameter int CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [iols_pkg::ACTION_W-1:0]         action,
  input  logic [iols_pkg::POSITION_W-1:0]       position,
  input  logic signed [iols_pkg::VALUE_W-1:0]   item_value,
  output logic                                  done,
  output logic signed [iols_pkg::VALUE_W-1:0]   read_value,
  output logic                                  accepted,
  output logic [iols_pkg::LENGTH_W-1:0]         list_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > iols_pkg::POSITION_W) ? CNT_W : iols_pkg::POSITION_W;
  localparam int LEN_W = (CMP_W > iols_pkg::LENGTH_W) ? CMP_W : iols_pkg::LENGTH_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  count_next;
  logic [CMP_W-1:0]                  count_ext;
  logic [CMP_W-1:0]                  pos_ext;
  logic [CMP_W-1:0]                  target;
  logic [LEN_W-1:0]                  len_ext;
  logic                              req;
  logic                              full;
  logic                              in_list;
  logic                              ok;
  logic [iols_pkg::VALUE_W-1:0]      rv;
  iols_pkg::cell_cmd_t               cmd;
  logic [iols_pkg::VALUE_W-1:0]      cell_q [CAPACITY];

  assign busy      = 1'b0;
  assign req       = start && !busy;
  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(position);
  assign full      = (count_ext == CAP_C);
  assign in_list   = (pos_ext < count_ext);

  // decode the request into a chain command, outcome and new length
  always_comb begin
    cmd        = '0;
    target     = pos_ext;
    ok         = 1'b0;
    rv         = '0;
    count_next = count;
    unique case (action)
      iols_pkg::ACT_READ: begin
        ok = in_list;
        rv = in_list ? cell_q[pos_ext[IDX_W-1:0]] : '1;
      end
      iols_pkg::ACT_FRONT, iols_pkg::ACT_BACK, iols_pkg::ACT_BEFORE: begin
        unique case (action)
          iols_pkg::ACT_FRONT: target = '0;
          iols_pkg::ACT_BACK:  target = count_ext;
          default:             target = pos_ext;
        endcase
        ok = !full && (target <= count_ext);
        cmd.ins = req && ok;
        if (ok) begin
          count_next = count + CNT_W'(1);
        end
      end
      iols_pkg::ACT_DELETE: begin
        ok = in_list;
        cmd.del = req && ok;
        if (ok) begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // chain of storage cells, each wired to its two neighbors
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [iols_pkg::VALUE_W-1:0] lower_q;
    logic [iols_pkg::VALUE_W-1:0] upper_q;
    if (k == 0) begin : g_first
      assign lower_q = item_value;
    end else begin : g_mid_lo
      assign lower_q = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign upper_q = cell_q[k];
    end else begin : g_mid_hi
      assign upper_q = cell_q[k+1];
    end
    iols_cell #(
      .IDX   (k),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .target    (target),
      .ins_value (item_value),
      .lower_q   (lower_q),
      .upper_q   (upper_q),
      .q         (cell_q[k])
    );
  end

  // advance the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req) begin
      count <= count_next;
    end
  end

  // strobe the result in the cycle after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req;
    end
  end

  assign len_ext = LEN_W'(count_next);

  // hold the result payload
  always_ff @(posedge clk) begin
    if (req) begin
      read_value  <= rv;
      accepted    <= ok;
      list_length <= len_ext[iols_pkg::LENGTH_W-1:0];
    end
  end

endmodule

>>> sv/iols_checker.sv
// ----------------------------------------------------------------------------
// iols_checker: port-level checks for the ordered list store
// Watches request and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module iols_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic [iols_pkg::ACTION_W-1:0]         action,
  input logic                                  done,
  input logic signed [iols_pkg::VALUE_W-1:0]   read_value,
  input logic                                  accepted,
  input logic [iols_pkg::LENGTH_W-1:0]         list_length
);

  // every accepted request gives a result in the next cycle
  a_done_follows: assert property (@(posedge clk)
    (!rst && start && !busy) |=> done)
    else $error("request without result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk)
    (rst || !(start && !busy)) |=> !done)
    else $error("result without request");

  // a read miss returns all ones
  a_read_miss: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted && ($past(action) == iols_pkg::ACT_READ)) |-> (read_value == -32'sd1))
    else $error("read miss value wrong");

  // non-read requests return zero data
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(action) != iols_pkg::ACT_READ)) |-> (read_value == 32'sd0))
    else $error("non-read returned data");

  // a successful front insert leaves a non-empty list
  a_ins_nonempty: assert property (@(posedge clk) disable iff (rst)
    (done && accepted && ($past(action) == iols_pkg::ACT_FRONT)) |-> (list_length != '0))
    else $error("insert left list empty");

endmodule

bind indexed_ordered_list_store_top iols_checker u_iols_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .action      (action),
  .done        (done),
  .read_value  (read_value),
  .accepted    (accepted),
  .list_length (list_length)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: request and result checking for the indexed ordered list store
// Sends read, insert and delete requests with random idle gaps, keeps its own
// shadow copy of the list to work out each expected result, and compares
// every result strobe field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  // action codes the block does not define
  localparam logic [iols_pkg::ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [iols_pkg::ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic signed [iols_pkg::VALUE_W-1:0] read_value;
    logic                                accepted;
    logic [iols_pkg::LENGTH_W-1:0]       list_length;
  } list_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [iols_pkg::ACTION_W-1:0]        action = '0;
  logic [iols_pkg::POSITION_W-1:0]      position = '0;
  logic signed [iols_pkg::VALUE_W-1:0]  item_value = '0;
  logic                                 done;
  logic signed [iols_pkg::VALUE_W-1:0]  read_value;
  logic                                 accepted;
  logic [iols_pkg::LENGTH_W-1:0]        list_length;

  // shadow copy of the list and the results it predicts
  logic signed [iols_pkg::VALUE_W-1:0]  shadow_entries [CAPACITY];
  int                                   shadow_count = 0;
  list_result_t                         pending_results [$];

  int fail_count     = 0;
  int request_count  = 0;
  int result_count   = 0;
  int taken_count    = 0;
  int refused_count  = 0;
  int full_hits      = 0;
  int cycle_count    = 0;
  int idle_max       = 0;
  int burst_left     = 0;

  indexed_ordered_list_store_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .position(position),
    .item_value(item_value),
    .done(done),
    .read_value(read_value),
    .accepted(accepted),
    .list_length(list_length)
  );

  always #5 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // open a slot at the target and shift the tail up
  function automatic bit shadow_insert(int where, logic signed [iols_pkg::VALUE_W-1:0] v);
    if (shadow_count >= CAPACITY) full_hits++;
    if (shadow_count >= CAPACITY || where > shadow_count) return 1'b0;
    for (int k = shadow_count; k > where; k--) shadow_entries[k] = shadow_entries[k-1];
    shadow_entries[where] = v;
    shadow_count++;
    return 1'b1;
  endfunction

  // close the slot at the target and shift the tail down
  function automatic bit shadow_delete(int where);
    if (where >= shadow_count) return 1'b0;
    for (int k = where; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k+1];
    shadow_count--;
    return 1'b1;
  endfunction

  // apply one request to the shadow list and queue the result it must give
  function automatic void predict_list_request(logic [iols_pkg::ACTION_W-1:0] act,
                                               logic [iols_pkg::POSITION_W-1:0] pos,
                                               logic signed [iols_pkg::VALUE_W-1:0] val);
    list_result_t r;
    r.read_value = '0;
    r.accepted   = 1'b0;
    case (act)
      iols_pkg::ACT_READ: begin
        if (int'(pos) < shadow_count) begin
          r.read_value = shadow_entries[pos];
          r.accepted   = 1'b1;
        end else begin
          r.read_value = -1;
        end
      end
      iols_pkg::ACT_FRONT:  r.accepted = shadow_insert(0, val);
      iols_pkg::ACT_BACK:   r.accepted = shadow_insert(shadow_count, val);
      iols_pkg::ACT_BEFORE: r.accepted = shadow_insert(int'(pos), val);
      iols_pkg::ACT_DELETE: r.accepted = shadow_delete(int'(pos));
      default:              r.accepted = 1'b0;
    endcase
    r.list_length = shadow_count[iols_pkg::LENGTH_W-1:0];
    if (r.accepted) taken_count++;
    else refused_count++;
    pending_results.push_back(r);
  endfunction

  // send one request: optional idle gap, then hold it until accepted
  task automatic send_request(logic [iols_pkg::ACTION_W-1:0] act,
                              logic [iols_pkg::POSITION_W-1:0] pos,
                              logic signed [iols_pkg::VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: idle_max = 0;
        1: idle_max = 2;
        default: idle_max = 12;
      endcase
    end
    burst_left--;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (busy);
    predict_list_request(act, pos, val);
    request_count++;
  endtask

  // check each result strobe against the oldest expectation
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && done) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: read_value %0d accepted %0b length %0d",
                 $time, read_value, accepted, list_length);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (read_value !== exp_r.read_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time, exp_r.read_value,
                   read_value);
          fail_count++;
        end
        if (accepted !== exp_r.accepted) begin
          $display("%0t: accepted expected %0b actual %0b", $time, exp_r.accepted, accepted);
          fail_count++;
        end
        if (list_length !== exp_r.list_length) begin
          $display("%0t: list_length expected %0d actual %0d", $time, exp_r.list_length,
                   list_length);
          fail_count++;
        end
      end
    end
  end

  // value with extra weight on the sign and range edges
  function automatic logic signed [iols_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // position mostly inside the list, sometimes anywhere in the field
  function automatic logic [iols_pkg::POSITION_W-1:0] pick_position(int span);
    int p;
    if (span > 0 && $urandom_range(0, 9) < 8) p = $urandom_range(0, span - 1);
    else p = $urandom_range(0, 127);
    return p[iols_pkg::POSITION_W-1:0];
  endfunction

  // edge cases on an empty list, all actions, misses and refusals
  task automatic test_directed();
    send_request(iols_pkg::ACT_READ, 7'd0, '0);
    send_request(iols_pkg::ACT_READ, 7'd127, '0);
    send_request(iols_pkg::ACT_DELETE, 7'd0, '0);
    send_request(iols_pkg::ACT_BEFORE, 7'd1, 32'sh1234_5678);
    send_request(iols_pkg::ACT_BEFORE, 7'd0, 32'sh7FFF_FFFF);
    send_request(iols_pkg::ACT_FRONT, 7'd0, 32'sh8000_0000);
    send_request(iols_pkg::ACT_BACK, 7'd0, -1);
    send_request(iols_pkg::ACT_BACK, 7'd127, '0);
    send_request(iols_pkg::ACT_BEFORE, 7'd2, 32'sh5A5A_5A5A);
    // position equal to the length appends
    send_request(iols_pkg::ACT_BEFORE, 7'd5, 32'sh0000_0001);
    send_request(iols_pkg::ACT_BEFORE, 7'd127, 32'shA5A5_A5A5);
    send_request(iols_pkg::ACT_READ, 7'd0, '0);
    send_request(iols_pkg::ACT_READ, 7'd2, '0);
    send_request(iols_pkg::ACT_READ, 7'd5, '0);
    send_request(iols_pkg::ACT_READ, 7'd6, '0);
    for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
      send_request(a[iols_pkg::ACTION_W-1:0], 7'd127, -1);
    send_request(iols_pkg::ACT_DELETE, 7'd127, '0);
    send_request(iols_pkg::ACT_DELETE, 7'd6, '0);
    send_request(iols_pkg::ACT_DELETE, 7'd5, '0);
    send_request(iols_pkg::ACT_DELETE, 7'd0, '0);
    send_request(iols_pkg::ACT_DELETE, 7'd2, '0);
    send_request(iols_pkg::ACT_READ, 7'd0, '0);
  endtask

  // random traffic; insert_pct steers the list toward full or empty
  task automatic test_random_traffic(int count, int insert_pct);
    logic [iols_pkg::ACTION_W-1:0] act;
    logic [iols_pkg::POSITION_W-1:0] pos;
    int roll;
    int code;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        case ($urandom_range(0, 2))
          0: act = iols_pkg::ACT_FRONT;
          1: act = iols_pkg::ACT_BACK;
          default: act = iols_pkg::ACT_BEFORE;
        endcase
        pos = pick_position(shadow_count + 1);
      end else if (roll < insert_pct + (100 - insert_pct) * 6 / 10) begin
        act = iols_pkg::ACT_DELETE;
        pos = pick_position(shadow_count);
      end else if (roll < 97) begin
        act = iols_pkg::ACT_READ;
        pos = pick_position(shadow_count);
      end else begin
        code = $urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST);
        act  = code[iols_pkg::ACTION_W-1:0];
        pos  = pick_position(0);
      end
      send_request(act, pos, pick_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(300, 85);
    test_random_traffic(300, 15);
    test_random_traffic(250, 85);
    test_random_traffic(250, 15);
    test_random_traffic(425, 50);

    // drain outstanding results, then let the output stage settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d requests, checked %0d results: %0d took effect, %0d refused or missed",
             request_count, result_count, taken_count, refused_count);
    $display("inserts that met a full store: %0d, mismatches: %0d", full_hits, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/iols_pkg.sv
sv/iols_cell.sv
sv/indexed_ordered_list_store_top.sv
sv/iols_checker.sv
verif/testbench.sv
